// ----- hdl/mfe_pkg.sv -----
// shared types and constants for the floor-extracting price multiset
// no dependencies
package mfe_pkg;
	localparam int PRICE_W = 30;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_NONE     = 2'd1,
		ST_INSERTED = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;
endpackage

// ----- hdl/multiset_floor_extract.sv -----
// floor-extracting price multiset: sorted entry memory with copy counts
// uses mfe_pkg and mfe_ram
//
// Usage: s_axis carries one item per transfer; tdata[0] is func (0 insert,
// 1 query), tdata[30:1] is the price or key. m_axis returns one result per
// item: tdata[1:0] status, tdata[31:2] the removed price (zero otherwise).
// Items are handled one at a time by a sequencer around one memory of
// {value, count} entries with a registered read.
// Steps: a binary search of about log2(used)+1 probes, each a read (S_SRD)
// and a compare (S_SCMP), then a closing S_SRD; a query then scans back over
// exhausted entries, S_QRD and S_QCHK per entry (ending in S_QRD when it runs
// off the bottom); an insert checks its entry (S_IRD, S_ICHK) and, for a new
// distinct value, moves each higher entry up (S_DEC, S_MRD, S_MWR) and then
// writes the new entry in a final S_DEC. An item is taken only after the last
// result has been transferred and S_IDLE is back; the memory port sets the pace.
// Reset clears the entry count and the other registers, not the memory; the memory needs no clearing pass.
// A stalled receiver holds the result in the output register; the next
// item is taken once the register is free, since there is one item in work.
module multiset_floor_extract
	import mfe_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // func, price_or_key, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // status, price_out
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = PRICE_W + COUNT_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCMP, S_DEC, S_QRD, S_QCHK,
		S_IRD, S_ICHK, S_MRD, S_MWR, S_OUT
	} state_t;

	state_t state_q;
	logic func_q;
	logic [PRICE_W-1:0] key_q;
	logic [UW-1:0] lo_q, hi_q, used_q, j_q;
	logic [1:0] status_q;
	logic [PRICE_W-1:0] price_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [PRICE_W-1:0] rval;
	logic [COUNT_W-1:0] rcnt;
	logic [UW-1:0] mid;
	logic left;

	assign rval = rdata[EW-1:COUNT_W];
	assign rcnt = rdata[COUNT_W-1:0];
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign left = (func_q == FUNC_QUERY) ? (rval <= key_q) : (rval < key_q);

	mfe_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		we = 1'b0;
		waddr = j_q[AW-1:0];
		wdata = rdata;
		raddr = mid[AW-1:0];
		case (state_q)
			S_QRD, S_MRD: raddr = AW'(j_q - UW'(1));
			S_IRD: raddr = lo_q[AW-1:0];
			S_QCHK: begin
				waddr = AW'(j_q - UW'(1));
				wdata = {rval, rcnt - COUNT_W'(1)};
				we = (rcnt != '0);
			end
			S_ICHK: begin
				waddr = lo_q[AW-1:0];
				wdata = {rval, rcnt + COUNT_W'(1)};
				we = (lo_q < used_q) && (rval == key_q) && (rcnt != COUNT_MAX);
			end
			S_MWR: begin
				waddr = j_q[AW-1:0];
				wdata = rdata;
				we = 1'b1;
			end
			S_DEC: begin
				waddr = lo_q[AW-1:0];
				wdata = {key_q, COUNT_W'(1)};
				we = (j_q == lo_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			func_q <= 1'b0;
			key_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			j_q <= '0;
			status_q <= ST_NONE;
			price_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					func_q <= s_axis_tdata[0];
					key_q <= s_axis_tdata[PRICE_W:1];
					lo_q <= '0;
					hi_q <= used_q;
					price_q <= '0;
					state_q <= S_SRD;
				end
				S_SRD: begin
					if (lo_q < hi_q) state_q <= S_SCMP;
					else if (func_q == FUNC_QUERY) begin
						j_q <= lo_q;
						state_q <= S_QRD;
					end else state_q <= S_IRD;
				end
				S_SCMP: begin
					if (left) lo_q <= mid + UW'(1);
					else hi_q <= mid;
					state_q <= S_SRD;
				end
				S_QRD: begin
					if (j_q == '0) begin
						status_q <= ST_NONE;
						state_q <= S_OUT;
					end else state_q <= S_QCHK;
				end
				S_QCHK: begin
					if (rcnt != '0) begin
						status_q <= ST_FOUND;
						price_q <= rval;
						state_q <= S_OUT;
					end else begin
						j_q <= j_q - UW'(1);
						state_q <= S_QRD;
					end
				end
				S_IRD: state_q <= S_ICHK;
				S_ICHK: begin
					if (lo_q < used_q && rval == key_q) begin
						status_q <= (rcnt == COUNT_MAX) ? ST_FULL : ST_INSERTED;
						state_q <= S_OUT;
					end else if (used_q >= UW'(TABLE_DEPTH)) begin
						status_q <= ST_FULL;
						state_q <= S_OUT;
					end else begin
						j_q <= used_q;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					// shift entries up one place, top first
					if (j_q == lo_q) begin
						used_q <= used_q + UW'(1);
						status_q <= ST_INSERTED;
						state_q <= S_OUT;
					end else state_q <= S_MRD;
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: begin
					j_q <= j_q - UW'(1);
					state_q <= S_DEC;
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {price_q, status_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_DEPTH)) else $error("entry count overflow");
	a_price_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_q != ST_FOUND |-> price_q == '0)
		else $error("price on non-found result");
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> used_q == $past(used_q) + UW'(1))
		else $error("entry count jumped");
endmodule

// ----- hdl/mfe_ram.sv -----
// generic single-port-write, single-read RAM with registered read
// no dependencies
module mfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
